@@ rtl/htw_pkg.sv @@
package htw_pkg;

  localparam int IDX_W     = 9;
  localparam int SYM_W     = 8;
  localparam int BYTE_BITS = 8;
  localparam int CNT_W     = 4;
  localparam int WORK_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH  = 2;

  localparam logic ACT_NODE = 1'b0;
  localparam logic ACT_DATA = 1'b1;

  typedef enum logic {
    ITEM_NODE,
    ITEM_DATA
  } item_kind_t;

  typedef struct packed {
    item_kind_t             kind;
    logic [IDX_W-1:0]       node_index;
    logic                   leaf;
    logic [SYM_W-1:0]       sym;
    logic [IDX_W-1:0]       left;
    logic [IDX_W-1:0]       right;
    logic [BYTE_BITS-1:0]   data;
    logic [CNT_W-1:0]       nbits;
  } work_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_CUR_RD,
    ST_CHILD_RD,
    ST_FLUSH
  } back_state_t;

endpackage

@@ rtl/htw_fifo.sv @@
module htw_fifo
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 2)
  (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

@@ rtl/htw_front.sv @@
module htw_front
  import htw_pkg::*;
  #(parameter int NODE_COUNT = 512)
  (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_action,
  input  logic [IDX_W-1:0]     in_node_index,
  input  logic                 in_node_is_leaf,
  input  logic [SYM_W-1:0]     in_node_symbol,
  input  logic [IDX_W-1:0]     in_left_child,
  input  logic [IDX_W-1:0]     in_right_child,
  input  logic [BYTE_BITS-1:0] in_data_byte,
  input  logic [CNT_W-1:0]     in_valid_bits,
  input  logic                 item_pop,
  output work_item_t           item,
  output logic                 item_empty
);

  work_item_t item_in;
  logic       keep;
  logic [$bits(work_item_t)-1:0] q_dout;

  // Clamp the bit count and drop items that leave no trace in the back end
  always_comb begin
    item_in.kind       = (in_action == ACT_DATA) ? ITEM_DATA : ITEM_NODE;
    item_in.node_index = in_node_index;
    item_in.leaf       = in_node_is_leaf;
    item_in.sym        = in_node_symbol;
    item_in.left       = in_left_child;
    item_in.right      = in_right_child;
    item_in.data       = in_data_byte;
    item_in.nbits      = (in_valid_bits > CNT_W'(BYTE_BITS)) ? CNT_W'(BYTE_BITS)
                                                             : in_valid_bits;
    if (in_action == ACT_DATA) begin
      keep = (in_valid_bits != '0);
    end else begin
      keep = (32'(in_node_index) < NODE_COUNT);
    end
  end

  htw_fifo #(
    .WIDTH ($bits(work_item_t)),
    .DEPTH (WORK_Q_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push & keep),
    .din   (item_in),
    .full  (full),
    .pop   (item_pop),
    .dout  (q_dout),
    .empty (item_empty)
  );

  assign item = work_item_t'(q_dout);

endmodule

@@ rtl/htw_back.sv @@
module htw_back
  import htw_pkg::*;
  #(parameter int NODE_COUNT  = 512,
    parameter int SYMBOL_BITS = 8)
  (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_wdata,
  input  work_item_t       item,
  input  logic             item_empty,
  output logic             item_pop,
  output logic             res_push,
  output result_t          res,
  input  logic             res_full
);

  localparam int AW     = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int NODE_W = 1 + SYMBOL_BITS + 2 * IDX_W;

  back_state_t state_r, state_nxt;

  logic [NODE_W-1:0]      node_mem_r [NODE_COUNT];
  logic [NODE_W-1:0]      rd_data_r;
  logic                   rd_oob_r;

  logic [IDX_W-1:0]       root_r, root_nxt;
  logic [IDX_W-1:0]       cursor_r, cursor_nxt;
  logic                   cur_v_r, cur_v_nxt;
  logic                   cur_leaf_r, cur_leaf_nxt;
  logic [SYMBOL_BITS-1:0] cur_sym_r, cur_sym_nxt;
  logic [IDX_W-1:0]       cur_left_r, cur_left_nxt;
  logic [IDX_W-1:0]       cur_right_r, cur_right_nxt;
  logic [BYTE_BITS-1:0]   bits_r, bits_nxt;
  logic [CNT_W-1:0]       left_r, left_nxt;
  logic                   pend_v_r, pend_v_nxt;
  logic [SYM_W-1:0]       pend_sym_r, pend_sym_nxt;
  logic [IDX_W-1:0]       next_idx_r, next_idx_nxt;

  logic                   rd_leaf;
  logic [SYMBOL_BITS-1:0] rd_sym;
  logic [IDX_W-1:0]       rd_left, rd_right;
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       rd_idx;
  logic [IDX_W-1:0]       child_sel;
  logic                   can_emit, last_bit;
  logic                   walk_leaf_emit, walk_inner, child_emit, child_inner;
  logic                   emit, consume, flush_push;
  logic [SYM_W-1:0]       emit_sym;

  // Out-of-range reads look like an inner node pointing at entry zero
  assign rd_leaf  = rd_oob_r ? 1'b0 : rd_data_r[NODE_W-1];
  assign rd_sym   = rd_oob_r ? '0 : rd_data_r[2*IDX_W +: SYMBOL_BITS];
  assign rd_left  = rd_oob_r ? '0 : rd_data_r[IDX_W +: IDX_W];
  assign rd_right = rd_oob_r ? '0 : rd_data_r[0 +: IDX_W];

  assign child_sel = bits_r[BYTE_BITS-1] ? cur_right_r : cur_left_r;
  assign can_emit  = ~pend_v_r | ~res_full;
  assign last_bit  = (left_r == CNT_W'(1));

  assign item_pop       = (state_r == ST_IDLE) & ~item_empty;
  assign mem_we         = item_pop & (item.kind == ITEM_NODE);
  assign walk_leaf_emit = (state_r == ST_WALK) & cur_v_r & cur_leaf_r & can_emit;
  assign walk_inner     = (state_r == ST_WALK) & cur_v_r & ~cur_leaf_r;
  assign child_emit     = (state_r == ST_CHILD_RD) & rd_leaf & can_emit;
  assign child_inner    = (state_r == ST_CHILD_RD) & ~rd_leaf;
  assign emit           = walk_leaf_emit | child_emit;
  assign consume        = emit | child_inner;
  assign flush_push     = (state_r == ST_FLUSH) & pend_v_r & ~res_full;
  assign emit_sym       = (state_r == ST_CHILD_RD) ? SYM_W'(rd_sym) : SYM_W'(cur_sym_r);

  // Fetch the cursor node, the chosen child, or the root right after a hit
  assign mem_re = ((state_r == ST_WALK) & ~cur_v_r) | walk_inner | (emit & ~last_bit);
  always_comb begin
    if (emit) begin
      rd_idx = root_r;
    end else if (walk_inner) begin
      rd_idx = child_sel;
    end else begin
      rd_idx = cursor_r;
    end
  end

  // Hold back the newest symbol so the byte's final one can carry last
  assign res_push = (emit & pend_v_r) | flush_push;
  assign res.sym  = pend_sym_r;
  assign res.last = (state_r == ST_FLUSH);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (!item_empty && item.kind == ITEM_DATA) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!cur_v_r) begin
          state_nxt = ST_CUR_RD;
        end else if (!cur_leaf_r) begin
          state_nxt = ST_CHILD_RD;
        end else if (consume) begin
          state_nxt = last_bit ? ST_FLUSH : ST_CUR_RD;
        end
      end
      ST_CUR_RD: begin
        state_nxt = ST_WALK;
      end
      ST_CHILD_RD: begin
        if (consume) begin
          if (last_bit) begin
            state_nxt = ST_FLUSH;
          end else begin
            state_nxt = emit ? ST_CUR_RD : ST_WALK;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r || !res_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    root_nxt      = root_r;
    cursor_nxt    = cursor_r;
    cur_v_nxt     = cur_v_r;
    cur_leaf_nxt  = cur_leaf_r;
    cur_sym_nxt   = cur_sym_r;
    cur_left_nxt  = cur_left_r;
    cur_right_nxt = cur_right_r;
    bits_nxt      = bits_r;
    left_nxt      = left_r;
    pend_v_nxt    = pend_v_r;
    pend_sym_nxt  = pend_sym_r;
    next_idx_nxt  = next_idx_r;

    if (item_pop && item.kind == ITEM_DATA) begin
      bits_nxt = item.data;
      left_nxt = item.nbits;
    end
    // A node write may have changed the cached cursor node
    if (mem_we) begin
      cur_v_nxt = 1'b0;
    end
    if (walk_inner) begin
      next_idx_nxt = child_sel;
    end
    if (state_r == ST_CUR_RD || child_inner) begin
      cur_v_nxt     = 1'b1;
      cur_leaf_nxt  = rd_leaf;
      cur_sym_nxt   = rd_sym;
      cur_left_nxt  = rd_left;
      cur_right_nxt = rd_right;
    end
    if (child_inner) begin
      cursor_nxt = next_idx_r;
    end
    if (consume) begin
      bits_nxt = {bits_r[BYTE_BITS-2:0], 1'b0};
      left_nxt = left_r - 1'b1;
    end
    if (emit) begin
      pend_v_nxt   = 1'b1;
      pend_sym_nxt = emit_sym;
      cursor_nxt   = root_r;
      cur_v_nxt    = 1'b0;
    end
    if (flush_push) begin
      pend_v_nxt = 1'b0;
    end
    if (cfg_we) begin
      root_nxt   = cfg_wdata;
      cursor_nxt = cfg_wdata;
      cur_v_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      root_r   <= '0;
      cursor_r <= '0;
      cur_v_r  <= 1'b0;
      left_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      root_r   <= root_nxt;
      cursor_r <= cursor_nxt;
      cur_v_r  <= cur_v_nxt;
      left_r   <= left_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_leaf_r  <= cur_leaf_nxt;
    cur_sym_r   <= cur_sym_nxt;
    cur_left_r  <= cur_left_nxt;
    cur_right_r <= cur_right_nxt;
    bits_r      <= bits_nxt;
    pend_sym_r  <= pend_sym_nxt;
    next_idx_r  <= next_idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem_r[AW'(item.node_index)] <= {item.leaf, SYMBOL_BITS'(item.sym),
                                           item.left, item.right};
    end
    if (mem_re) begin
      rd_data_r <= node_mem_r[AW'(rd_idx)];
      rd_oob_r  <= ~(32'(rd_idx) < NODE_COUNT);
    end
  end

endmodule

@@ rtl/huffman_tree_walk_decoder.sv @@
// Node-load transaction: enters the work queue, written to the node table when the idle walker
// pops it from the head. Data byte of n bits: one dependent read per tree step on the single
// node-table read port, one more to refetch the root after a symbol, plus dequeue and flush
// and a fetch of the cursor node when it is not cached. A symbol is held until the byte's next
// symbol or its flush, then shows on the result ports. Sync active-low reset clears queues,
// walk state, root and cursor to 0.
module huffman_tree_walk_decoder
  import htw_pkg::*;
  #(parameter int NODE_COUNT  = 512,
    parameter int SYMBOL_BITS = 8)
  (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [IDX_W-1:0]     cfg_wdata,
  input  logic                 push,
  output logic                 full,
  input  logic                 in_action,
  input  logic [IDX_W-1:0]     in_node_index,
  input  logic                 in_node_is_leaf,
  input  logic [SYM_W-1:0]     in_node_symbol,
  input  logic [IDX_W-1:0]     in_left_child,
  input  logic [IDX_W-1:0]     in_right_child,
  input  logic [BYTE_BITS-1:0] in_data_byte,
  input  logic [CNT_W-1:0]     in_valid_bits,
  output logic                 empty,
  input  logic                 pop,
  output logic [SYM_W-1:0]     out_symbol,
  output logic                 out_last
);

  work_item_t item;
  logic       item_empty, item_pop;
  logic       res_push, res_full;
  result_t    res, res_out;
  logic [$bits(result_t)-1:0] res_dout;

  htw_front #(
    .NODE_COUNT (NODE_COUNT)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_action       (in_action),
    .in_node_index   (in_node_index),
    .in_node_is_leaf (in_node_is_leaf),
    .in_node_symbol  (in_node_symbol),
    .in_left_child   (in_left_child),
    .in_right_child  (in_right_child),
    .in_data_byte    (in_data_byte),
    .in_valid_bits   (in_valid_bits),
    .item_pop        (item_pop),
    .item            (item),
    .item_empty      (item_empty)
  );

  htw_back #(
    .NODE_COUNT  (NODE_COUNT),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  htw_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_dout),
    .empty (empty)
  );

  assign res_out    = result_t'(res_dout);
  assign out_symbol = res_out.sym;
  assign out_last   = res_out.last;

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import htw_pkg::*;

  localparam int NODES      = 512;
  localparam int SETTLE     = 120;  // cycles for in-flight work that yields no symbol
  localparam int RAND_ITEMS = 430;
  localparam int IDLE_PCT   = 22;
  // Watchdog limit on the whole run, in ns.
  localparam longint RUN_LIMIT_NS = 3_000_000;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] sym;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } tree_node_t;

  typedef enum logic { ROW_ITEM, ROW_ROOT } row_kind_t;

  typedef struct {
    row_kind_t        kind;
    work_item_t       item;
    logic [IDX_W-1:0] root;
    bit               typed;
    int               n_sym;
    logic [SYM_W-1:0] sym;
  } stim_row_t;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_we          = 1'b0;
  logic [IDX_W-1:0]     cfg_wdata       = '0;
  logic                 push            = 1'b0;
  logic                 full;
  logic                 in_action       = 1'b0;
  logic [IDX_W-1:0]     in_node_index   = '0;
  logic                 in_node_is_leaf = 1'b0;
  logic [SYM_W-1:0]     in_node_symbol  = '0;
  logic [IDX_W-1:0]     in_left_child   = '0;
  logic [IDX_W-1:0]     in_right_child  = '0;
  logic [BYTE_BITS-1:0] in_data_byte    = '0;
  logic [CNT_W-1:0]     in_valid_bits   = '0;
  logic                 empty;
  logic                 pop             = 1'b0;
  logic [SYM_W-1:0]     out_symbol;
  logic                 out_last;

  huffman_tree_walk_decoder u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .push           (push),
    .full           (full),
    .in_action      (in_action),
    .in_node_index  (in_node_index),
    .in_node_is_leaf(in_node_is_leaf),
    .in_node_symbol (in_node_symbol),
    .in_left_child  (in_left_child),
    .in_right_child (in_right_child),
    .in_data_byte   (in_data_byte),
    .in_valid_bits  (in_valid_bits),
    .empty          (empty),
    .pop            (pop),
    .out_symbol     (out_symbol),
    .out_last       (out_last)
  );

  always #5 clk = ~clk;

  // Mirror of the decoder state
  tree_node_t       node_mem [NODES];
  bit               node_written [NODES];
  logic [IDX_W-1:0] written_idx[$];
  logic [IDX_W-1:0] root_reg = '0;
  logic [IDX_W-1:0] cursor   = '0;
  result_t          walk_syms[$];  // symbols from the latest transaction
  result_t          sym_q[$];      // symbols the block still owes
  stim_row_t        stim_rows[$];
  int               n_err    = 0;
  int               n_items  = 0;
  logic             calm;

  assign calm = (n_items >= 170) && (n_items < 260);

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    n_err++;
  endtask

  function automatic void walk_item(input work_item_t it);
    tree_node_t       cur;
    tree_node_t       hit;
    logic [IDX_W-1:0] nxt;
    int               nbits;
    logic             emit;
    walk_syms.delete();
    if (it.kind == ITEM_NODE) begin
      node_mem[it.node_index] = '{it.leaf, it.sym, it.left, it.right};
      if (!node_written[it.node_index]) begin
        node_written[it.node_index] = 1'b1;
        written_idx.push_back(it.node_index);
      end
      return;
    end
    nbits = (it.nbits > BYTE_BITS) ? BYTE_BITS : int'(it.nbits);
    for (int b = 0; b < nbits; b++) begin
      cur  = node_mem[cursor];
      emit = 1'b0;
      hit  = cur;
      if (cur.leaf) begin
        emit = 1'b1;
      end else begin
        nxt = it.data[BYTE_BITS-1-b] ? cur.right : cur.left;
        hit = node_mem[nxt];
        if (hit.leaf) emit = 1'b1;
        else cursor = nxt;
      end
      if (emit) begin
        walk_syms.push_back('{hit.sym, 1'b0});
        cursor = root_reg;
      end
    end
    if (walk_syms.size() > 0) walk_syms[walk_syms.size()-1].last = 1'b1;
  endfunction

  function automatic work_item_t rand_item(input item_kind_t kind);
    work_item_t it;
    int         v;
    it.kind       = kind;
    it.node_index = IDX_W'($urandom_range(NODES - 1, 0));
    it.leaf       = 1'($urandom_range(1, 0));
    it.sym        = SYM_W'($urandom_range(255, 0));
    it.left       = IDX_W'($urandom_range(NODES - 1, 0));
    it.right      = IDX_W'($urandom_range(NODES - 1, 0));
    it.data       = BYTE_BITS'($urandom_range(255, 0));
    v = $urandom_range(99, 0);
    // zero consumes nothing, counts above a byte clamp to a full byte
    if (v < 4) it.nbits = '0;
    else if (v < 9) it.nbits = CNT_W'($urandom_range(15, BYTE_BITS + 1));
    else it.nbits = CNT_W'($urandom_range(BYTE_BITS, 1));
    return it;
  endfunction

  // Random node write; an inner node only points at entries already written.
  function automatic work_item_t noise_node();
    work_item_t it;
    it = rand_item(ITEM_NODE);
    if ($urandom_range(1, 0) != 0)
      it.node_index = written_idx[$urandom_range(written_idx.size() - 1, 0)];
    if (!it.leaf) begin
      it.left  = written_idx[$urandom_range(written_idx.size() - 1, 0)];
      it.right = written_idx[$urandom_range(written_idx.size() - 1, 0)];
    end
    return it;
  endfunction

  function automatic void node_row(input logic [IDX_W-1:0] idx, input logic leaf,
                                   input logic [SYM_W-1:0] sym,
                                   input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r);
    stim_row_t row;
    row.kind            = ROW_ITEM;
    row.item            = rand_item(ITEM_NODE);
    row.item.node_index = idx;
    row.item.leaf       = leaf;
    row.item.sym        = sym;
    row.item.left       = l;
    row.item.right      = r;
    row.root            = '0;
    row.typed           = 1'b1;
    row.n_sym           = 0;
    row.sym             = '0;
    stim_rows.push_back(row);
  endfunction

  function automatic void data_row(input logic [BYTE_BITS-1:0] data,
                                   input logic [CNT_W-1:0] nbits, input bit typed,
                                   input int n_sym, input logic [SYM_W-1:0] sym);
    stim_row_t row;
    row.kind       = ROW_ITEM;
    row.item       = rand_item(ITEM_DATA);
    row.item.data  = data;
    row.item.nbits = nbits;
    row.root       = '0;
    row.typed      = typed;
    row.n_sym      = n_sym;
    row.sym        = sym;
    stim_rows.push_back(row);
  endfunction

  function automatic void root_row(input logic [IDX_W-1:0] v);
    stim_row_t row;
    row.kind  = ROW_ROOT;
    row.item  = rand_item(ITEM_NODE);
    row.root  = v;
    row.typed = 1'b0;
    row.n_sym = 0;
    row.sym   = '0;
    stim_rows.push_back(row);
  endfunction

  task automatic push_item(input work_item_t it, input bit typed, input int n_sym,
                           input logic [SYM_W-1:0] sym);
    @(negedge clk);
    while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
      push <= 1'b0;
      @(negedge clk);
    end
    in_action       <= (it.kind == ITEM_DATA) ? ACT_DATA : ACT_NODE;
    in_node_index   <= it.node_index;
    in_node_is_leaf <= it.leaf;
    in_node_symbol  <= it.sym;
    in_left_child   <= it.left;
    in_right_child  <= it.right;
    in_data_byte    <= it.data;
    in_valid_bits   <= it.nbits;
    push            <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    n_items++;
    walk_item(it);
    // typed rows carry their own answer; the mirror still advances
    if (typed) begin
      walk_syms.delete();
      for (int k = 0; k < n_sym; k++) walk_syms.push_back('{sym, 1'(k == n_sym - 1)});
    end
    foreach (walk_syms[k]) sym_q.push_back(walk_syms[k]);
  endtask

  task automatic drain_block();
    @(negedge clk);
    push <= 1'b0;
    while (sym_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_root(input logic [IDX_W-1:0] v);
    drain_block();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
    root_reg = v;
    cursor   = v;
  endtask

  // Grow a full binary tree by splitting random leaves, then load it in a rotated order.
  task automatic load_tree(input logic [IDX_W-1:0] root, input int leaves);
    logic [IDX_W-1:0] pos_idx[$];
    bit               pos_leaf[$];
    int               pos_l[$];
    int               pos_r[$];
    bit               taken [NODES];
    int               p;
    int               start;
    logic [IDX_W-1:0] v;
    work_item_t       it;
    pos_idx.push_back(root);
    pos_leaf.push_back(1'b1);
    pos_l.push_back(0);
    pos_r.push_back(0);
    taken[root] = 1'b1;
    repeat (leaves - 1) begin
      do p = $urandom_range(pos_idx.size() - 1, 0); while (!pos_leaf[p]);
      pos_leaf[p] = 1'b0;
      pos_l[p]    = pos_idx.size();
      pos_r[p]    = pos_idx.size() + 1;
      repeat (2) begin
        do begin
          if ($urandom_range(9, 0) == 0) v = ($urandom_range(1, 0) != 0) ? '1 : '0;
          else v = IDX_W'($urandom_range(NODES - 1, 0));
        end while (taken[v]);
        taken[v] = 1'b1;
        pos_idx.push_back(v);
        pos_leaf.push_back(1'b1);
        pos_l.push_back(0);
        pos_r.push_back(0);
      end
    end
    start = $urandom_range(pos_idx.size() - 1, 0);
    for (int j = 0; j < pos_idx.size(); j++) begin
      p             = (start + j) % pos_idx.size();
      it            = rand_item(ITEM_NODE);
      it.node_index = pos_idx[p];
      it.leaf       = pos_leaf[p];
      if (!pos_leaf[p]) begin
        it.left  = pos_idx[pos_l[p]];
        it.right = pos_idx[pos_r[p]];
      end
      push_item(it, 1'b0, 0, '0);
    end
  endtask

  always @(negedge clk) pop <= calm || ($urandom_range(99, 0) >= IDLE_PCT);

  always @(posedge clk) begin : check_symbols
    result_t want;
    if (rst_n && !empty && pop) begin
      if (sym_q.size() == 0) begin
        report_mismatch($sformatf("symbol %02h with nothing owed", out_symbol));
      end else begin
        want = sym_q.pop_front();
        if (out_symbol !== want.sym)
          report_mismatch($sformatf("symbol got %02h want %02h", out_symbol, want.sym));
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %b want %b (symbol %02h)",
                                    out_last, want.last, want.sym));
      end
    end
  end

  initial begin : stimulus
    int               n_dir;
    int               n_data;
    int               phase;
    logic [IDX_W-1:0] root;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // codes from root 0: 0 -> 00, 10 -> FF, 11 -> A5
    node_row(9'd0,   1'b0, 8'h00, 9'd1,   9'd2);
    node_row(9'd1,   1'b1, 8'h00, 9'h1FF, 9'h000);
    node_row(9'd2,   1'b0, 8'hFF, 9'd3,   9'd511);
    node_row(9'd3,   1'b1, 8'hFF, 9'h0AA, 9'h155);
    node_row(9'd511, 1'b1, 8'hA5, 9'h1FF, 9'h1FF);
    data_row(8'h00, 4'd8,  1'b1, 8, 8'h00);
    data_row(8'hFF, 4'd8,  1'b1, 4, 8'hA5);
    data_row(8'h80, 4'd2,  1'b1, 1, 8'hFF);
    data_row(8'hFF, 4'd0,  1'b1, 0, 8'h00);
    data_row(8'h00, 4'd15, 1'b1, 8, 8'h00);
    // code split across two bytes
    data_row(8'h80, 4'd1,  1'b1, 0, 8'h00);
    data_row(8'h7F, 4'd1,  1'b1, 1, 8'hFF);
    // half-walked code dropped by a root write
    data_row(8'h80, 4'd1,  1'b1, 0, 8'h00);
    root_row(9'd0);
    data_row(8'h00, 4'd1,  1'b1, 1, 8'h00);
    // root on a leaf: every bit gives the root symbol
    root_row(9'd511);
    data_row(8'h5A, 4'd3,  1'b1, 3, 8'hA5);
    root_row(9'd2);
    data_row(8'h6C, 4'd8,  1'b0, 0, 8'h00);
    node_row(9'd3,   1'b1, 8'h3C, 9'h000, 9'h1FF);
    data_row(8'h0F, 4'd4,  1'b0, 0, 8'h00);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_ROOT) load_root(stim_rows[i].root);
      else push_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].n_sym,
                     stim_rows[i].sym);
    end

    n_dir = n_items;
    phase = 0;
    while (n_items < n_dir + RAND_ITEMS) begin
      case (phase % 4)
        0:       root = '1;
        1:       root = '0;
        default: root = IDX_W'($urandom_range(NODES - 1, 0));
      endcase
      load_root(root);
      load_tree(root, (phase % 5 == 2) ? 1 : $urandom_range(9, 2));
      n_data = $urandom_range(40, 15);
      repeat (n_data) begin
        if ($urandom_range(9, 0) == 0) push_item(noise_node(), 1'b0, 0, '0);
        else push_item(rand_item(ITEM_DATA), 1'b0, 0, '0);
      end
      phase++;
    end

    drain_block();
    if (n_err == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("FAIL");
    $finish;
  end

endmodule
